>>> sv/sli_pkg.sv
package sli_pkg;

  // Default coordinate width of the line deltas and offsets.
  localparam int COORD_BITS_DEFAULT = 16;

  // Field widths fixed by the interface.
  localparam int ACTION_BITS    = 2;
  localparam int PULSE_BITS     = 16;
  localparam int SPEED_BITS     = 4;
  localparam int DELAY_BITS     = 6;
  localparam int CFG_INDEX_BITS = 1;
  localparam int CFG_DATA_BITS  = 16;

  // Request kinds carried on the input tuser.
  localparam logic [ACTION_BITS-1:0] ACT_LOAD    = 2'd0;
  localparam logic [ACTION_BITS-1:0] ACT_ADVANCE = 2'd1;
  localparam logic [ACTION_BITS-1:0] ACT_STOP    = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_BITS-1:0] CFG_PULSES = 1'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SPEED  = 1'd1;

  // Reset values of the configuration registers.
  localparam logic [PULSE_BITS-1:0] PULSES_RESET = 16'd1;
  localparam logic [SPEED_BITS-1:0] SPEED_RESET  = 4'd0;

  // Pulse delay is DELAY_BASE minus five per speed level, zero from SPEED_MAX up.
  localparam logic [DELAY_BITS-1:0] DELAY_BASE = 6'd50;
  localparam logic [SPEED_BITS-1:0] SPEED_MAX  = 4'd10;

  // Settings handed from the configuration block to the datapath.
  typedef struct packed {
    logic [PULSE_BITS-1:0] pulses;
    logic [DELAY_BITS-1:0] delay;
  } cfg_t;

endpackage

>>> sv/sli_cfg.sv
module sli_cfg (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [sli_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [sli_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  output sli_pkg::cfg_t                        cfg
);

  logic [sli_pkg::PULSE_BITS-1:0] pulses;
  logic [sli_pkg::DELAY_BITS-1:0] delay;
  logic [sli_pkg::DELAY_BITS-1:0] delay_next;
  logic [sli_pkg::SPEED_BITS-1:0] speed_in;
  logic [sli_pkg::DELAY_BITS-1:0] speed_x5;

  // Writes are always taken.
  assign cfg_ready = 1'b1;

  // Speed level times five, as a shift and an add.
  assign speed_in = cfg_data[sli_pkg::SPEED_BITS-1:0];
  assign speed_x5 = (sli_pkg::DELAY_BITS'(speed_in) << 2) + sli_pkg::DELAY_BITS'(speed_in);

  // The delay is worked out once, when the speed is written, and saturates at zero.
  always_comb begin
    if (speed_in >= sli_pkg::SPEED_MAX) begin
      delay_next = '0;
    end else begin
      delay_next = sli_pkg::DELAY_BASE - speed_x5;
    end
  end

  // Register file.
  always_ff @(posedge clk) begin
    if (rst) begin
      pulses <= sli_pkg::PULSES_RESET;
      delay  <= sli_pkg::DELAY_BASE;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        sli_pkg::CFG_PULSES: pulses <= cfg_data[sli_pkg::PULSE_BITS-1:0];
        sli_pkg::CFG_SPEED:  delay  <= delay_next;
        default: ;
      endcase
    end
  end

  assign cfg.pulses = pulses;
  assign cfg.delay  = delay;

endmodule

>>> sv/sli_in_stage.sv
module sli_in_stage #(
  parameter int COORD_BITS = sli_pkg::COORD_BITS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_valid,
  output logic                            s_ready,
  input  logic [sli_pkg::ACTION_BITS-1:0] s_action,
  input  logic [COORD_BITS-1:0]           s_dx,
  input  logic [COORD_BITS-1:0]           s_dy,
  input  logic                            item_take,
  output logic                            item_valid,
  output logic [sli_pkg::ACTION_BITS-1:0] item_action,
  output logic [COORD_BITS-1:0]           item_dx,
  output logic [COORD_BITS-1:0]           item_dy
);

  // A new request enters when the register is empty or its request moves on this cycle.
  assign s_ready = !item_valid || item_take;

  // Occupancy of the input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_ready) begin
      item_valid <= s_valid;
    end
  end

  // Request payload.
  always_ff @(posedge clk) begin
    if (s_valid && s_ready) begin
      item_action <= s_action;
      item_dx     <= s_dx;
      item_dy     <= s_dy;
    end
  end

endmodule

>>> sv/sli_core.sv
module sli_core #(
  parameter int COORD_BITS = sli_pkg::COORD_BITS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            item_valid,
  input  logic [sli_pkg::ACTION_BITS-1:0] item_action,
  input  logic [COORD_BITS-1:0]           item_dx,
  input  logic [COORD_BITS-1:0]           item_dy,
  output logic                            item_take,
  input  sli_pkg::cfg_t                   cfg,
  input  logic                            res_ready,
  output logic                            res_valid,
  output logic                            res_step_valid,
  output logic                            res_step_axis,
  output logic                            res_moving_positive,
  output logic                            res_dir_pin_level,
  output logic [sli_pkg::PULSE_BITS-1:0]  res_pulse_count,
  output logic [sli_pkg::DELAY_BITS-1:0]  res_pulse_delay,
  output logic [COORD_BITS-1:0]           res_x_offset,
  output logic [COORD_BITS-1:0]           res_y_offset,
  output logic                            res_last_step,
  output logic                            res_busy
);

  localparam int ABS_BITS = COORD_BITS + 1;
  localparam int ERR_BITS = COORD_BITS + 2;
  localparam logic [ABS_BITS-1:0] POS_UP   = ABS_BITS'(1);
  localparam logic [ABS_BITS-1:0] POS_DOWN = '1;

  // Line state.
  logic [ERR_BITS-1:0] error_term,      error_term_next;
  logic [ABS_BITS-1:0] remaining_steps, remaining_steps_next;
  logic [ABS_BITS-1:0] abs_dx,          abs_dx_next;
  logic [ABS_BITS-1:0] abs_dy,          abs_dy_next;
  logic                x_forward,       x_forward_next;
  logic                y_forward,       y_forward_next;
  logic [ABS_BITS-1:0] x_position,      x_position_next;
  logic [ABS_BITS-1:0] y_position,      y_position_next;

  logic [ABS_BITS-1:0] dx_ext, dy_ext, dx_mag, dy_mag;
  logic [ABS_BITS:0]   mag_sum;
  logic                step_valid, step_axis, moving_positive, dir_pin, last_step;

  // The request is processed when the result register is free or being emptied.
  assign item_take = item_valid && (!res_valid || res_ready);

  // Magnitudes of the new deltas, one bit wider so the most negative value fits.
  assign dx_ext  = {item_dx[COORD_BITS-1], item_dx};
  assign dy_ext  = {item_dy[COORD_BITS-1], item_dy};
  assign dx_mag  = item_dx[COORD_BITS-1] ? (~dx_ext + POS_UP) : dx_ext;
  assign dy_mag  = item_dy[COORD_BITS-1] ? (~dy_ext + POS_UP) : dy_ext;
  assign mag_sum = {1'b0, dx_mag} + {1'b0, dy_mag};

  // One interpolation step, a line load or a stop.
  always_comb begin
    error_term_next      = error_term;
    remaining_steps_next = remaining_steps;
    abs_dx_next          = abs_dx;
    abs_dy_next          = abs_dy;
    x_forward_next       = x_forward;
    y_forward_next       = y_forward;
    x_position_next      = x_position;
    y_position_next      = y_position;
    step_valid           = 1'b0;
    step_axis            = 1'b0;
    moving_positive      = 1'b0;
    dir_pin              = 1'b0;
    last_step            = 1'b0;
    unique case (item_action)
      sli_pkg::ACT_LOAD: begin
        abs_dx_next          = dx_mag;
        abs_dy_next          = dy_mag;
        // A zero delta counts as the negative direction.
        x_forward_next       = !item_dx[COORD_BITS-1] && (item_dx != '0);
        y_forward_next       = !item_dy[COORD_BITS-1] && (item_dy != '0);
        remaining_steps_next = mag_sum[ABS_BITS-1:0];
        error_term_next      = '0;
        x_position_next      = '0;
        y_position_next      = '0;
      end
      sli_pkg::ACT_ADVANCE: begin
        if (remaining_steps != '0) begin
          step_valid = 1'b1;
          if (!error_term[ERR_BITS-1]) begin
            // Error at or above zero: step along x.
            moving_positive = x_forward;
            dir_pin         = !x_forward;
            x_position_next = x_position + (x_forward ? POS_UP : POS_DOWN);
            error_term_next = error_term - {1'b0, abs_dy};
          end else begin
            // Error below zero: step along y.
            step_axis       = 1'b1;
            moving_positive = y_forward;
            dir_pin         = y_forward;
            y_position_next = y_position + (y_forward ? POS_UP : POS_DOWN);
            error_term_next = error_term + {1'b0, abs_dx};
          end
          remaining_steps_next = remaining_steps - POS_UP;
          last_step            = (remaining_steps == POS_UP);
        end
      end
      sli_pkg::ACT_STOP: begin
        last_step            = (remaining_steps != '0);
        remaining_steps_next = '0;
      end
      default: ;
    endcase
  end

  // State update.
  always_ff @(posedge clk) begin
    if (rst) begin
      error_term      <= '0;
      remaining_steps <= '0;
      abs_dx          <= '0;
      abs_dy          <= '0;
      x_forward       <= 1'b0;
      y_forward       <= 1'b0;
      x_position      <= '0;
      y_position      <= '0;
    end else if (item_take) begin
      error_term      <= error_term_next;
      remaining_steps <= remaining_steps_next;
      abs_dx          <= abs_dx_next;
      abs_dy          <= abs_dy_next;
      x_forward       <= x_forward_next;
      y_forward       <= y_forward_next;
      x_position      <= x_position_next;
      y_position      <= y_position_next;
    end
  end

  // Result register occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (item_take) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (item_take) begin
      res_step_valid      <= step_valid;
      res_step_axis       <= step_axis;
      res_moving_positive <= moving_positive;
      res_dir_pin_level   <= dir_pin;
      res_pulse_count     <= cfg.pulses;
      res_pulse_delay     <= cfg.delay;
      res_x_offset        <= x_position_next[COORD_BITS-1:0];
      res_y_offset        <= y_position_next[COORD_BITS-1:0];
      res_last_step       <= last_step;
      res_busy            <= (remaining_steps_next != '0);
    end
  end

endmodule

>>> sv/stepper_line_interpolator_unit.sv
// An accepted request passes the input register, then the result register, to the master side.
// Throughput: one request per cycle; the error update and step count decrement of
// one increment are combinational between the registers, so requests follow back to back unless
// a result is held on the master side, which then stalls the slave side.
// Reset (rst, synchronous, active high) clears the line state and both stages and
// returns pulses per increment to 1 and speed level to 0.
module stepper_line_interpolator_unit #(
  parameter int COORD_BITS = sli_pkg::COORD_BITS_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  // Slave side.
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // tdata fields from bit 0: delta_x, delta_y, zero padding.
  input  logic [((2*COORD_BITS+7)/8)*8-1:0]  s_axis_tdata,
  // tuser fields from bit 0: action.
  input  logic [sli_pkg::ACTION_BITS-1:0]    s_axis_tuser,
  // Master side.
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // tdata fields from bit 0: step_valid, step_axis, moving_positive, dir_pin_level,
  // pulse_count, pulse_delay, x_offset, y_offset, busy_res, zero padding.
  output logic [((2*COORD_BITS+27+7)/8)*8-1:0] m_axis_tdata,
  output logic                               m_axis_tlast,
  // Configuration write channel.
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [sli_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [sli_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  localparam int OUT_FIELD_BITS = 2*COORD_BITS + 27;
  localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS+7)/8)*8;

  sli_pkg::cfg_t                   cfg;
  logic                            item_take;
  logic                            item_valid;
  logic [sli_pkg::ACTION_BITS-1:0] item_action;
  logic [COORD_BITS-1:0]           item_dx;
  logic [COORD_BITS-1:0]           item_dy;
  logic                            res_step_valid;
  logic                            res_step_axis;
  logic                            res_moving_positive;
  logic                            res_dir_pin_level;
  logic [sli_pkg::PULSE_BITS-1:0]  res_pulse_count;
  logic [sli_pkg::DELAY_BITS-1:0]  res_pulse_delay;
  logic [COORD_BITS-1:0]           res_x_offset;
  logic [COORD_BITS-1:0]           res_y_offset;
  logic                            res_busy;
  logic [OUT_FIELD_BITS-1:0]       out_fields;

  // Configuration registers.
  sli_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Input register.
  sli_in_stage #(.COORD_BITS(COORD_BITS)) u_in (
    .clk         (clk),
    .rst         (rst),
    .s_valid     (s_axis_tvalid),
    .s_ready     (s_axis_tready),
    .s_action    (s_axis_tuser),
    .s_dx        (s_axis_tdata[COORD_BITS-1:0]),
    .s_dy        (s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
    .item_take   (item_take),
    .item_valid  (item_valid),
    .item_action (item_action),
    .item_dx     (item_dx),
    .item_dy     (item_dy)
  );

  // Interpolation datapath and result register.
  sli_core #(.COORD_BITS(COORD_BITS)) u_core (
    .clk                 (clk),
    .rst                 (rst),
    .item_valid          (item_valid),
    .item_action         (item_action),
    .item_dx             (item_dx),
    .item_dy             (item_dy),
    .item_take           (item_take),
    .cfg                 (cfg),
    .res_ready           (m_axis_tready),
    .res_valid           (m_axis_tvalid),
    .res_step_valid      (res_step_valid),
    .res_step_axis       (res_step_axis),
    .res_moving_positive (res_moving_positive),
    .res_dir_pin_level   (res_dir_pin_level),
    .res_pulse_count     (res_pulse_count),
    .res_pulse_delay     (res_pulse_delay),
    .res_x_offset        (res_x_offset),
    .res_y_offset        (res_y_offset),
    .res_last_step       (m_axis_tlast),
    .res_busy            (res_busy)
  );

  // Result packing, first field in the lowest bits.
  assign out_fields = {res_busy, res_y_offset, res_x_offset, res_pulse_delay,
                       res_pulse_count, res_dir_pin_level, res_moving_positive,
                       res_step_axis, res_step_valid};
  assign m_axis_tdata = OUT_DATA_BITS'(out_fields);

  // The slave side stalls only behind a result that is waiting to be taken.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without a waiting result");

  // A result without a step carries no axis or direction.
  a_no_step_clean: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !res_step_valid) |->
      (!res_step_axis && !res_moving_positive && !res_dir_pin_level))
    else $error("direction reported without a step");

  // The step that ends a line leaves no increments behind.
  a_last_not_busy: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tlast) |-> !res_busy)
    else $error("line ended with increments remaining");

  // The pulse delay never exceeds its base value.
  a_delay_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (res_pulse_delay <= sli_pkg::DELAY_BASE))
    else $error("pulse delay out of range");

endmodule

>>> bench/tb.sv
module tb;
  import sli_pkg::*;

  localparam int COORD_BITS = COORD_BITS_DEFAULT;
  localparam int S_DATA_BITS = ((2*COORD_BITS+7)/8)*8;
  localparam int M_DATA_BITS = ((2*COORD_BITS+27+7)/8)*8;
  localparam logic [ACTION_BITS-1:0] ACT_UNUSED = 2'd3;
  localparam int PULSE_DELAY_STEP = 5;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam int MAX_REPORTS = 10;

  // One result as it appears on the master side, tlast included.
  typedef struct packed {
    logic                     step_valid;
    logic                     step_axis;
    logic                     moving_positive;
    logic                     dir_pin;
    logic [PULSE_BITS-1:0]    pulse_count;
    logic [DELAY_BITS-1:0]    pulse_delay;
    logic [COORD_BITS-1:0]    x_off;
    logic [COORD_BITS-1:0]    y_off;
    logic                     last;
    logic                     busy;
  } motion_t;

  logic clk = 1'b0;
  logic rst;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [S_DATA_BITS-1:0] s_axis_tdata;
  logic [ACTION_BITS-1:0] s_axis_tuser;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b1;
  logic [M_DATA_BITS-1:0] m_axis_tdata;
  logic m_axis_tlast;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;

  // Line state and settings as the block should hold them.
  logic signed [COORD_BITS+1:0] err_acc;
  logic [COORD_BITS:0] steps_left;
  logic [COORD_BITS:0] span_x;
  logic [COORD_BITS:0] span_y;
  logic fwd_x;
  logic fwd_y;
  logic signed [COORD_BITS:0] pos_x;
  logic signed [COORD_BITS:0] pos_y;
  logic [PULSE_BITS-1:0] cur_pulses;
  logic [SPEED_BITS-1:0] cur_speed;

  motion_t motion_q[$];
  int mismatch_count = 0;
  int reqs_sent = 0;
  int stall_left = 0;
  int quiet_cycles = 0;
  bit gaps_on = 1'b1;

  stepper_line_interpolator_unit u_top (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tlast(m_axis_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Advance the expected line state by one request and return the result it causes.
  function automatic motion_t predict_motion(input logic [ACTION_BITS-1:0] act,
                                             input logic signed [COORD_BITS-1:0] dx,
                                             input logic signed [COORD_BITS-1:0] dy);
    motion_t r;
    logic signed [COORD_BITS:0] wide_x;
    logic signed [COORD_BITS:0] wide_y;
    r = '0;
    case (act)
      ACT_LOAD: begin
        wide_x = dx;
        wide_y = dy;
        span_x = (wide_x < 0) ? -wide_x : wide_x;
        span_y = (wide_y < 0) ? -wide_y : wide_y;
        steps_left = span_x + span_y;
        // A zero delta counts as moving in the negative direction.
        fwd_x = (dx > 0);
        fwd_y = (dy > 0);
        err_acc = '0;
        pos_x = '0;
        pos_y = '0;
      end
      ACT_ADVANCE: begin
        if (steps_left != 0) begin
          r.step_valid = 1'b1;
          if (err_acc >= 0) begin
            r.moving_positive = fwd_x;
            r.dir_pin = !fwd_x;
            pos_x = fwd_x ? pos_x + 1 : pos_x - 1;
            err_acc = err_acc - $signed({1'b0, span_y});
          end else begin
            r.step_axis = 1'b1;
            r.moving_positive = fwd_y;
            r.dir_pin = fwd_y;
            pos_y = fwd_y ? pos_y + 1 : pos_y - 1;
            err_acc = err_acc + $signed({1'b0, span_x});
          end
          steps_left = steps_left - 1'b1;
          r.last = (steps_left == 0);
        end
      end
      ACT_STOP: begin
        r.last = (steps_left != 0);
        steps_left = '0;
      end
      default: begin
      end
    endcase
    r.pulse_count = cur_pulses;
    r.pulse_delay = (cur_speed >= SPEED_MAX) ? '0 :
                    DELAY_BASE - DELAY_BITS'(PULSE_DELAY_STEP * cur_speed);
    r.x_off = pos_x[COORD_BITS-1:0];
    r.y_off = pos_y[COORD_BITS-1:0];
    r.busy = (steps_left != 0);
    return r;
  endfunction

  function automatic string describe(input motion_t r);
    return $sformatf({"step %0d axis %0d pos %0d pin %0d pulses %0d delay %0d",
                      " x %0d y %0d last %0d busy %0d"},
                     r.step_valid, r.step_axis, r.moving_positive, r.dir_pin, r.pulse_count,
                     r.pulse_delay, $signed(r.x_off), $signed(r.y_off), r.last, r.busy);
  endfunction

  task automatic flag_mismatch(input string what, input string want, input motion_t got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("%0t %s: expected %s, got %s", $time, what, want, describe(got));
    end
  endtask

  // Send one request, with an occasional idle burst in front of it.
  task automatic send_req(input logic [ACTION_BITS-1:0] act,
                          input logic [COORD_BITS-1:0] dx,
                          input logic [COORD_BITS-1:0] dy);
    int gap;
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 3);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= act;
    s_axis_tdata <= {dy, dx};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    motion_q.push_back(predict_motion(act, dx, dy));
    reqs_sent++;
  endtask

  task automatic wait_drained();
    while (motion_q.size() != 0) @(posedge clk);
  endtask

  // Write both registers once the block has delivered every pending result.
  task automatic set_config(input logic [PULSE_BITS-1:0] pulses,
                            input logic [SPEED_BITS-1:0] speed);
    s_axis_tvalid <= 1'b0;
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= CFG_PULSES;
    cfg_data <= pulses;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cur_pulses = pulses;
    cfg_index <= CFG_SPEED;
    cfg_data <= {{(CFG_DATA_BITS-SPEED_BITS){1'b0}}, speed};
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cur_speed = speed;
    cfg_valid <= 1'b0;
  endtask

  // Load a line, take a number of increments and optionally abort it.
  task automatic run_line(input logic [COORD_BITS-1:0] dx, input logic [COORD_BITS-1:0] dy,
                          input int advances, input bit stop_after);
    send_req(ACT_LOAD, dx, dy);
    repeat (advances) send_req(ACT_ADVANCE, COORD_BITS'($urandom), COORD_BITS'($urandom));
    if (stop_after) begin
      send_req(ACT_STOP, COORD_BITS'($urandom), COORD_BITS'($urandom));
    end
  endtask

  // A short line, mostly run to completion with a few spare increments.
  task automatic run_short_line();
    logic [COORD_BITS-1:0] dx;
    logic [COORD_BITS-1:0] dy;
    int ix;
    int iy;
    int total;
    dx = COORD_BITS'($urandom_range(0, 40)) - COORD_BITS'(20);
    dy = COORD_BITS'($urandom_range(0, 40)) - COORD_BITS'(20);
    ix = $signed(dx);
    iy = $signed(dy);
    total = (ix < 0 ? -ix : ix) + (iy < 0 ? -iy : iy);
    if ($urandom_range(0, 4) == 0) begin
      run_line(dx, dy, $urandom_range(0, total), 1'b1);
    end else begin
      run_line(dx, dy, total + $urandom_range(0, 2), 1'b0);
    end
  endtask

  // Behaviour with no line loaded and with the reset settings.
  task automatic test_reset_defaults();
    send_req(ACT_ADVANCE, '0, '0);
    send_req(ACT_UNUSED, '1, '1);
    send_req(ACT_STOP, '0, '1);
    send_req(ACT_LOAD, '0, '0);
    send_req(ACT_ADVANCE, '1, '0);
  endtask

  // Complete lines, aborted lines, extreme deltas and a reload in mid-line.
  task automatic test_directed_lines();
    run_line(16'sd3, -16'sd2, 6, 1'b1);
    run_line(-16'sd4, 16'sd7, 3, 1'b1);
    run_line(16'sd32767, -16'sd32768, 3, 1'b1);
    run_line(-16'sd32768, -16'sd32768, 4, 1'b0);
    run_line(16'sd1, 16'sd1, 2, 1'b0);
    run_line(16'sd0, -16'sd2, 2, 1'b0);
  endtask

  // Zero and full pulse counts, and speeds at and beyond the saturation point.
  task automatic test_config_extremes();
    set_config('0, SPEED_MAX);
    run_line(16'sd2, 16'sd1, 3, 1'b0);
    set_config('1, '1);
    run_line(-16'sd1, -16'sd1, 1, 1'b1);
    set_config(PULSES_RESET, SPEED_RESET);
    run_line(16'sd1, -16'sd1, 2, 1'b0);
  endtask

  // Mostly short well-formed lines, some wide lines run part way, noise and setting changes.
  task automatic test_random_lines(input int target);
    int pick;
    logic [PULSE_BITS-1:0] pulses;
    while (reqs_sent < target) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        run_short_line();
      end else if (pick < 80) begin
        run_line(COORD_BITS'($urandom), COORD_BITS'($urandom), $urandom_range(1, 40),
                 1'($urandom_range(0, 1)));
      end else if (pick < 96) begin
        repeat ($urandom_range(1, 4)) begin
          send_req(ACTION_BITS'($urandom_range(1, 3)), COORD_BITS'($urandom),
                   COORD_BITS'($urandom));
        end
      end else begin
        case ($urandom_range(0, 3))
          0: pulses = '0;
          1: pulses = PULSES_RESET;
          2: pulses = '1;
          default: pulses = PULSE_BITS'($urandom);
        endcase
        set_config(pulses, SPEED_BITS'($urandom_range(0, 15)));
      end
    end
  endtask

  // Closing stretch at full rate on both sides.
  task automatic test_full_rate(input int target);
    gaps_on = 1'b0;
    set_config(PULSE_BITS'($urandom), SPEED_BITS'($urandom_range(0, 10)));
    while (reqs_sent < target) begin
      run_short_line();
    end
  endtask

  // Compare each delivered result with the oldest one predicted; pace the receiver.
  always @(posedge clk) begin
    motion_t got;
    motion_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.step_valid = m_axis_tdata[0];
      got.step_axis = m_axis_tdata[1];
      got.moving_positive = m_axis_tdata[2];
      got.dir_pin = m_axis_tdata[3];
      got.pulse_count = m_axis_tdata[19:4];
      got.pulse_delay = m_axis_tdata[25:20];
      got.x_off = m_axis_tdata[41:26];
      got.y_off = m_axis_tdata[57:42];
      got.busy = m_axis_tdata[58];
      got.last = m_axis_tlast;
      if (motion_q.size() == 0) begin
        flag_mismatch("unexpected result", "nothing", got);
      end else begin
        want = motion_q.pop_front();
        if (got !== want) begin
          flag_mismatch("result mismatch", describe(want), got);
        end
      end
    end
    if (stall_left != 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (gaps_on && $urandom_range(0, 5) == 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= $urandom_range(0, 2);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // End the run if nothing moves on any channel for too long.
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    s_axis_tuser <= ACT_LOAD;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_PULSES;
    cfg_data <= '0;
    err_acc = '0;
    steps_left = '0;
    span_x = '0;
    span_y = '0;
    fwd_x = 1'b0;
    fwd_y = 1'b0;
    pos_x = '0;
    pos_y = '0;
    cur_pulses = PULSES_RESET;
    cur_speed = SPEED_RESET;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_directed_lines();
    test_config_extremes();
    test_random_lines(800);
    test_full_rate(900);
    s_axis_tvalid <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> stepper_line_interpolator_unit.f
sv/sli_pkg.sv
sv/sli_cfg.sv
sv/sli_in_stage.sv
sv/sli_core.sv
sv/stepper_line_interpolator_unit.sv
bench/tb.sv
